// ===== rtl/core/sfpq_pkg.sv =====
// Shared types and constants for the super-normal float quantizer.
// Used by sfpq_round and superfp_quantizer_top; depends on nothing else.

package sfpq_pkg;

  // Width of the signed exponent arithmetic; span reaches 8 * 2^23.
  localparam int unsigned ExpW = 30;

  // Width of one IEEE single bit pattern.
  localparam int unsigned WordW = 32;

  // Widths of the configuration port.
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 5;

  // Register indexes on the configuration port.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_MANTISSA_BITS   = 2'd0,
    CFG_EXPONENT_BITS   = 2'd1,
    CFG_BINADE_COUNT    = 2'd2,
    CFG_SATURATE_ENABLE = 2'd3
  } cfg_idx_e;

  // Format settings as held in the configuration registers.
  typedef struct packed {
    logic [4:0] mantissa_bits;
    logic [3:0] exponent_bits;
    logic [3:0] binade_count;
    logic       saturate_enable;
  } fmt_cfg_t;

  // Reset values of the format settings.
  localparam logic [4:0] MantissaBitsRst = 5'd7;
  localparam logic [3:0] ExponentBitsRst = 4'd8;
  localparam logic [3:0] BinadeCountRst  = 4'd1;

  // Bit pattern constants.
  localparam logic [WordW-1:0] MagMask     = 32'h7FFF_FFFF;
  localparam logic [WordW-1:0] InfPattern  = 32'h7F80_0000;
  localparam logic [WordW-1:0] HalfExpStep = 32'h0040_0000;
  localparam logic [WordW-1:0] ExpSignMask = 32'hFF80_0000;
  localparam logic [7:0]       ExpBias     = 8'd127;
  localparam logic [7:0]       MaxField    = 8'd254;
  localparam logic [7:0]       SpecialExp  = 8'd255;

endpackage

// ===== rtl/core/sfpq_round.sv =====
// Combinational quantizer datapath: one IEEE single pattern in, one out.
// Depends on sfpq_pkg for the format settings type and constants.

module sfpq_round (
  input  sfpq_pkg::fmt_cfg_t                cfg_i,
  input  logic [sfpq_pkg::WordW-1:0]        value_i,
  output logic [sfpq_pkg::WordW-1:0]        result_o
);

  localparam logic signed [sfpq_pkg::ExpW-1:0] One  = 1;
  localparam logic signed [sfpq_pkg::ExpW-1:0] Zero = 0;
  localparam logic signed [sfpq_pkg::ExpW-1:0] Bias = 127;

  logic [4:0] m;
  logic [3:0] e;
  logic [3:0] b;
  logic       sat;

  logic signed [sfpq_pkg::ExpW-1:0] half_s, b_s, span_s, x_s;
  logic signed [sfpq_pkg::ExpW-1:0] emin_s, emax_s, low_thr_s, top_s, ovf_thr_s;
  logic [7:0]                       field;
  logic [sfpq_pkg::WordW-1:0]       sign_w, largest, pow_r, rne_r;
  logic [4:0]                       sh;
  logic [sfpq_pkg::WordW-1:0]       rmask, rhalf;
  logic [sfpq_pkg::WordW:0]         rsum;
  logic                             is_nan_or_inf, is_inf, exact_pow;

  // Clamp the settings into their meaningful ranges.
  assign m   = (cfg_i.mantissa_bits > 5'd23) ? 5'd23 : cfg_i.mantissa_bits;
  assign e   = (cfg_i.exponent_bits < 4'd2) ? 4'd2 :
               ((cfg_i.exponent_bits > 4'd8) ? 4'd8 : cfg_i.exponent_bits);
  assign b   = (cfg_i.binade_count < 4'd1) ? 4'd1 :
               ((cfg_i.binade_count > 4'd8) ? 4'd8 : cfg_i.binade_count);
  assign sat = cfg_i.saturate_enable;

  // Exponent window bounds and the power-of-two span beyond it.
  assign half_s    = $signed(sfpq_pkg::ExpW'(1) << (e - 4'd1));
  assign b_s       = $signed(sfpq_pkg::ExpW'(b));
  assign span_s    = $signed(sfpq_pkg::ExpW'(b) << m);
  assign emin_s    = b_s - half_s;
  assign emax_s    = half_s - One - b_s;
  assign low_thr_s = emin_s - span_s + One;
  assign top_s     = emax_s + span_s;
  assign ovf_thr_s = top_s - One + (sat ? One : Zero);
  assign x_s       = $signed(sfpq_pkg::ExpW'(value_i[30:23])) - Bias;

  // Largest representable value: exponent field of top, clamped at 254.
  assign field   = (top_s > Bias) ? sfpq_pkg::MaxField : 8'(top_s + Bias);
  assign sign_w  = {value_i[31], 31'd0};
  assign largest = sign_w | {1'b0, field, 23'd0};

  // Round to the nearest power of two, ties away from zero.
  assign pow_r = (value_i + sfpq_pkg::HalfExpStep) & sfpq_pkg::ExpSignMask;

  // Round to nearest even at bit 23-M of the pattern.
  assign sh    = 5'd23 - m;
  assign rmask = ~(32'hFFFF_FFFF << sh);
  assign rhalf = 32'd1 << (sh - 5'd1);
  assign rsum  = 33'(value_i) + 33'(rhalf - 32'd1) + 33'(value_i[sh]);
  assign rne_r = (m == 5'd23) ? value_i : (rsum[31:0] & ~rmask);

  assign is_nan_or_inf = (value_i[30:23] == sfpq_pkg::SpecialExp);
  assign is_inf        = ((value_i & sfpq_pkg::MagMask) == sfpq_pkg::InfPattern);
  assign exact_pow     = (value_i[22:0] == 23'd0) && (x_s == top_s - One);

  // Select the result by exponent region.
  always_comb begin
    if (x_s < emin_s) begin
      result_o = (x_s < low_thr_s) ? '0 : pow_r;
    end else if (x_s > emax_s) begin
      if (is_nan_or_inf) begin
        result_o = (sat && is_inf) ? largest : value_i;
      end else if (x_s >= ovf_thr_s) begin
        if (sat) begin
          result_o = largest;
        end else if (exact_pow) begin
          result_o = value_i;
        end else begin
          result_o = sign_w | sfpq_pkg::InfPattern;
        end
      end else begin
        result_o = pow_r;
      end
    end else begin
      result_o = rne_r;
    end
  end

endmodule

// ===== rtl/core/superfp_quantizer_top.sv =====
// Top level of the super-normal float quantizer: stream ports, config port,
// input and result registers. Depends on sfpq_pkg and sfpq_round.
//
// Usage:
// Each transfer on the s_axis channel carries one IEEE single bit pattern.
// The block returns one transfer on the m_axis channel per input, holding
// the value quantized to the format set by the four configuration
// registers (mantissa bits, exponent bits, binade count, saturate enable).
// Registers are written through cfg_we_i / cfg_addr_i / cfg_wdata_i while
// no item is in flight; the user must keep to this, since the block does
// not enforce it. A write takes effect at the next clock edge. An accepted
// item is held in the input register, then the quantized value is loaded
// into the result register and shown on m_axis. Throughput is one item per
// cycle while the receiver does not stall, set by the single combinational
// pass of sfpq_round between those two registers. When the receiver stalls,
// the result register holds, and the input register keeps accepting until
// it is also full, so s_axis_tready drops only when both stages hold data.
// Reset empties both stages and loads the registers with mantissa_bits 7,
// exponent_bits 8, binade_count 1 and saturation off.

module superfp_quantizer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [sfpq_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [sfpq_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sfpq_pkg::WordW-1:0]      s_axis_tdata,  // [31:0] value_bits
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sfpq_pkg::WordW-1:0]      m_axis_tdata   // [31:0] result_bits
);

  sfpq_pkg::fmt_cfg_t cfg_q, cfg_d;

  logic                         in_vld_q;
  logic [sfpq_pkg::WordW-1:0]   in_data_q;
  logic                         out_vld_q;
  logic [sfpq_pkg::WordW-1:0]   out_data_q;
  logic [sfpq_pkg::WordW-1:0]   result;
  logic                         out_load;
  logic                         in_load;

  // Configuration register decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (sfpq_pkg::cfg_idx_e'(cfg_addr_i))
        sfpq_pkg::CFG_MANTISSA_BITS:   cfg_d.mantissa_bits   = cfg_wdata_i[4:0];
        sfpq_pkg::CFG_EXPONENT_BITS:   cfg_d.exponent_bits   = cfg_wdata_i[3:0];
        sfpq_pkg::CFG_BINADE_COUNT:    cfg_d.binade_count    = cfg_wdata_i[3:0];
        sfpq_pkg::CFG_SATURATE_ENABLE: cfg_d.saturate_enable = cfg_wdata_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mantissa_bits   <= sfpq_pkg::MantissaBitsRst;
      cfg_q.exponent_bits   <= sfpq_pkg::ExponentBitsRst;
      cfg_q.binade_count    <= sfpq_pkg::BinadeCountRst;
      cfg_q.saturate_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline flow: the result stage loads when empty or being drained.
  assign out_load      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_data_q <= s_axis_tdata;
    end
  end

  // Quantizer datapath.
  sfpq_round u_round (
    .cfg_i    (cfg_q),
    .value_i  (in_data_q),
    .result_o (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_vld_q) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // An item in the input stage moves to the result stage when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_load) |=> out_vld_q)
    else $error("item lost between input and result stage");

  // Input is refused only when both stages are full and the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input refused while pipeline has room");

  // A NaN moving to the result stage comes out unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_load && (in_data_q[30:23] == sfpq_pkg::SpecialExp) &&
     (in_data_q[22:0] != 23'd0))
    |=> (m_axis_tdata == $past(in_data_q)))
    else $error("NaN not passed through");

endmodule

// ===== tb/tb_superfp_quantizer_top.sv =====
// Self-checking testbench for the super-normal float quantizer top level.
// Drives the input stream and config port, predicts every quantized word
// and checks the result stream. Depends on sfpq_pkg and superfp_quantizer_top.
`timescale 1ns / 100ps

module tb_superfp_quantizer_top;

  // One accepted operand and the word it must quantize to.
  typedef struct {
    logic [sfpq_pkg::WordW-1:0] operand;
    logic [sfpq_pkg::WordW-1:0] quantized;
  } quant_pair_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  sfpq_pkg::cfg_idx_e            cfg_addr_i = sfpq_pkg::CFG_MANTISSA_BITS;
  logic [sfpq_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [sfpq_pkg::WordW-1:0]    s_axis_tdata = '0;   // [31:0] value_bits
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [sfpq_pkg::WordW-1:0]    m_axis_tdata;        // [31:0] result_bits

  // Shadow copy of the format registers.
  logic [4:0] fmt_mant = sfpq_pkg::MantissaBitsRst;
  logic [3:0] fmt_exp = sfpq_pkg::ExponentBitsRst;
  logic [3:0] fmt_binade = sfpq_pkg::BinadeCountRst;
  logic       fmt_sat = 1'b0;

  logic [sfpq_pkg::WordW-1:0] operand_queue [$];
  quant_pair_t                pending_results [$];

  logic        operand_taken = 1'b0;
  logic        sender_hold = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [8:0]  stall_phase = '0;

  int unsigned operands_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned formats_tried = 1;

  superfp_quantizer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Exponent window of the current format, with registers saturated to range.
  function automatic void format_bounds(output int unsigned keep, output longint emin,
                                        output longint emax, output longint span,
                                        output longint top);
    longint ew, bc, half_range;
    keep = (fmt_mant > 5'd23) ? 23 : fmt_mant;
    ew = (fmt_exp < 4'd2) ? 2 : ((fmt_exp > 4'd8) ? 8 : fmt_exp);
    bc = (fmt_binade < 4'd1) ? 1 : ((fmt_binade > 4'd8) ? 8 : fmt_binade);
    half_range = longint'(1) << (ew - 1);
    emin = 1 - half_range + (bc - 1);
    emax = half_range - 2 - (bc - 1);
    span = bc * (longint'(1) << keep);
    top = emax + span;
  endfunction

  // Quantizes one single-precision pattern to the current format.
  function automatic logic [sfpq_pkg::WordW-1:0] quantize_value(
      logic [sfpq_pkg::WordW-1:0] t);
    longint      emin, emax, span, top, field, x;
    int unsigned keep, sh;
    logic [sfpq_pkg::WordW-1:0] sign, largest, to_power, mask, r;
    logic [sfpq_pkg::WordW:0]   rounded;
    format_bounds(keep, emin, emax, span, top);
    sign = t & 32'h8000_0000;
    x = longint'(t[30:23]) - longint'(sfpq_pkg::ExpBias);
    field = top + longint'(sfpq_pkg::ExpBias);
    if (field > longint'(sfpq_pkg::MaxField)) field = longint'(sfpq_pkg::MaxField);
    if (field < 0) field = 0;
    largest = sign | (32'(field) << 23);
    to_power = (t + sfpq_pkg::HalfExpStep) & sfpq_pkg::ExpSignMask;

    if (x < emin) begin
      // Below the window: power-of-two rounding, deep underflow flushes to +0.
      r = (x < emin - span + 1) ? '0 : to_power;
    end else if (x > emax) begin
      if (x == 128) begin
        r = (fmt_sat && (t & sfpq_pkg::MagMask) == sfpq_pkg::InfPattern) ? largest : t;
      end else if (fmt_sat && x >= top) begin
        r = largest;
      end else if (!fmt_sat && x >= top - 1) begin
        // Only an exact power at the very top survives without saturation.
        r = (t[22:0] == '0 && x == top - 1) ? t : (sign | sfpq_pkg::InfPattern);
      end else begin
        r = to_power;
      end
    end else if (keep >= 23) begin
      r = t;
    end else begin
      // Round to nearest even at the kept mantissa LSB.
      sh = 23 - keep;
      mask = (32'd1 << sh) - 32'd1;
      rounded = {1'b0, t} + 33'((32'd1 << (sh - 1)) - 32'd1) + 33'(t[sh]);
      r = rounded[sfpq_pkg::WordW-1:0] & ~mask;
    end
    return r;
  endfunction

  // Random operand aimed at the window edges of the current format.
  function automatic logic [sfpq_pkg::WordW-1:0] make_operand();
    longint      emin, emax, span, top, field;
    int unsigned keep, sh;
    logic [22:0] frac;
    format_bounds(keep, emin, emax, span, top);
    frac = 23'($urandom());
    case ($urandom_range(0, 5))
      0: frac = '0;
      1: frac = '1;
      2: begin
        // Exact tie at the kept mantissa LSB.
        if (keep < 23) begin
          sh = 23 - keep;
          frac = (frac & ~((23'd1 << sh) - 23'd1)) | (23'd1 << (sh - 1));
        end
      end
      3: frac = ($urandom_range(0, 1) != 0) ? 23'h40_0000 : 23'h3F_FFFF;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: field = longint'($urandom_range(0, 255));
      1: field = emin + 125 + longint'($urandom_range(0, 3));
      2: field = emin - span + 126 + longint'($urandom_range(0, 3));
      3: field = emax + 126 + longint'($urandom_range(0, 3));
      4: field = top + 125 + longint'($urandom_range(0, 3));
      5: field = 255;
      6: field = 0;
      default: begin
        if (emin <= emax) begin
          field = emin + 127 + longint'($urandom_range(0, 32'(emax - emin)));
        end else begin
          field = longint'($urandom_range(0, 255));
        end
      end
    endcase
    if (field < 0) field = 0;
    if (field > 255) field = 255;
    return {1'($urandom_range(0, 1)), 8'(field), frac};
  endfunction

  // Writes all four format registers and updates the shadow copy.
  task automatic write_format(input logic [4:0] mant, input logic [4:0] expw,
                              input logic [4:0] binades, input logic sat);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= sfpq_pkg::CFG_MANTISSA_BITS;
    cfg_wdata_i <= mant;
    @(negedge clk_i);
    fmt_mant = mant;
    cfg_addr_i <= sfpq_pkg::CFG_EXPONENT_BITS;
    cfg_wdata_i <= expw;
    @(negedge clk_i);
    fmt_exp = expw[3:0];
    cfg_addr_i <= sfpq_pkg::CFG_BINADE_COUNT;
    cfg_wdata_i <= binades;
    @(negedge clk_i);
    fmt_binade = binades[3:0];
    cfg_addr_i <= sfpq_pkg::CFG_SATURATE_ENABLE;
    cfg_wdata_i <= {4'd0, sat};
    @(negedge clk_i);
    fmt_sat = sat;
    cfg_we_i <= 1'b0;
    formats_tried++;
    @(posedge clk_i);
  endtask

  // Waits until every operand is taken and every result has come back.
  task automatic drain_pipeline();
    while (operand_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One format setting with a batch of random operands.
  task automatic run_format(input logic [4:0] mant, input logic [4:0] expw,
                            input logic [4:0] binades, input logic sat,
                            input int unsigned count, input logic pause_midway);
    int unsigned start_count;
    write_format(mant, expw, binades, sat);
    start_count = operands_sent;
    repeat (count) operand_queue.push_back(make_operand());
    if (pause_midway) begin
      // Hold the sender until the block has emptied, then resume.
      while (operands_sent < start_count + count / 2) @(negedge clk_i);
      @(posedge clk_i);
      sender_hold = 1'b1;
      while (s_axis_tvalid || pending_results.size() != 0) @(negedge clk_i);
      repeat (6) @(negedge clk_i);
      @(posedge clk_i);
      sender_hold = 1'b0;
    end
    drain_pipeline();
  endtask

  // Input driver: bursts of transfers separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !operand_taken) begin
      // The current transfer stays on the bus until it is taken.
    end else if (gap_left != 0) begin
      gap_left--;
      s_axis_tvalid <= 1'b0;
    end else if (!sender_hold && operand_queue.size() != 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= operand_queue[0];
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      end else begin
        burst_left--;
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Result receiver: stall behavior changes with the upper bits of a phase counter.
  always @(negedge clk_i) begin
    stall_phase = stall_phase + 9'd1;
    case (stall_phase[8:6])
      3'd0, 3'd1: m_axis_tready <= 1'b1;
      3'd2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      3'd3:       m_axis_tready <= (stall_phase[3:0] > 4'd10);
      3'd4:       m_axis_tready <= 1'($urandom_range(0, 1));
      default:    m_axis_tready <= stall_phase[0];
    endcase
  end

  // Input monitor: each accepted transfer gets its expected result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      operand_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back('{s_axis_tdata, quantize_value(s_axis_tdata)});
        void'(operand_queue.pop_front());
        operands_sent++;
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation.
  always @(posedge clk_i) begin
    quant_pair_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result %08h", $realtime, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_axis_tdata !== want.quantized) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] operand %08h: expected %08h, got %08h", $realtime,
                     want.operand, want.quantized, m_axis_tdata);
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner values under the reset format.
    operand_queue.push_back(32'h0000_0000);  // positive zero
    operand_queue.push_back(32'h8000_0000);  // negative zero
    operand_queue.push_back(32'h7F80_0000);  // positive infinity
    operand_queue.push_back(32'hFF80_0000);  // negative infinity
    operand_queue.push_back(32'h7FC0_0001);  // quiet NaN
    operand_queue.push_back(32'hFF80_0001);  // signaling NaN, negative
    operand_queue.push_back(32'hFFFF_FFFF);  // all ones
    operand_queue.push_back(32'h3F80_0000);  // one
    operand_queue.push_back(32'h7F7F_FFFF);  // largest finite, carries to infinity
    operand_queue.push_back(32'h7F00_0000);  // exact power above the window
    operand_queue.push_back(32'h0000_0001);  // smallest denormal
    operand_queue.push_back(32'h3F80_8000);  // tie, even LSB stays
    operand_queue.push_back(32'h3F81_8000);  // tie, odd LSB rounds up
    operand_queue.push_back(32'hBF7F_FFFF);  // mantissa carry into exponent
    drain_pipeline();

    // Narrow format: window is 2^-3 .. 2^2, top power is 2^5.
    write_format(5'd2, 5'd3, 5'd1, 1'b0);
    operand_queue.push_back(32'h3D80_0000);  // exact power below the window
    operand_queue.push_back(32'h3D40_0000);  // tie below the window, away from zero
    operand_queue.push_back(32'hBD3F_FFFF);  // just under a tie, negative
    operand_queue.push_back(32'h3C80_0000);  // lowest power kept
    operand_queue.push_back(32'h3C00_0000);  // deep underflow
    operand_queue.push_back(32'hBC7F_FFFF);  // deep underflow, negative gives +0
    operand_queue.push_back(32'h4200_0000);  // exact top power passes
    operand_queue.push_back(32'h4220_0000);  // overflow to infinity
    operand_queue.push_back(32'hC280_0000);  // negative overflow
    operand_queue.push_back(32'h4170_0000);  // above the window, rounds up a power
    drain_pipeline();

    // Random operands over a spread of formats, extremes included.
    run_format(5'd0,  5'd2,  5'd1,  1'b0, 60, 1'b0);
    run_format(5'd22, 5'd8,  5'd8,  1'b1, 60, 1'b0);
    run_format(5'd0,  5'd8,  5'd1,  1'b1, 60, 1'b0);
    run_format(5'd3,  5'd4,  5'd2,  1'b0, 60, 1'b1);
    run_format(5'd10, 5'd5,  5'd3,  1'b1, 60, 1'b0);
    run_format(5'd1,  5'd3,  5'd8,  1'b0, 60, 1'b0);
    run_format(5'd31, 5'd15, 5'd15, 1'b1, 60, 1'b0);
    run_format(5'd0,  5'd0,  5'd0,  1'b0, 60, 1'b0);
    run_format(5'd7,  5'd8,  5'd1,  1'b1, 60, 1'b0);

    $display("Quantized %0d operands and checked %0d results across %0d formats,",
             operands_sent, results_checked, formats_tried);
    $display("covering window edges, ties, underflow, overflow and saturation.");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sfpq_pkg.sv
rtl/core/sfpq_round.sv
rtl/core/superfp_quantizer_top.sv
tb/tb_superfp_quantizer_top.sv
